// ----- rtl/smet_pkg.sv -----
// ---------------------------------------------------------------------------
// smet_pkg
// shared types and constants for the sparse matrix entry table
// ---------------------------------------------------------------------------
package smet_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = 16;
    localparam int VAL_W    = 32;

    typedef enum logic [1:0] {
        CMD_SET = 2'd0,
        CMD_GET = 2'd1,
        CMD_DEL = 2'd2,
        CMD_NOP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_OOB  = 2'd1,
        STS_FULL = 2'd2
    } t_status;

    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // write-phase operation broadcast to every cell
    typedef struct packed {
        logic             upd;
        logic             clr;
        logic             ins;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_op;

    // compare-phase key broadcast to every cell
    typedef struct packed {
        logic             cmp;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_key;

    // data passed from one cell to the next
    typedef struct packed {
        logic             free_seen;
        logic             hit_seen;
        logic [VAL_W-1:0] rd;
    } t_link;

endpackage

// ----- rtl/smet_cell.sv -----
// ---------------------------------------------------------------------------
// smet_cell
// one table entry: compare against the key, update, clear or claim
// ---------------------------------------------------------------------------
module smet_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  smet_pkg::t_key i_key,
    input  smet_pkg::t_op  i_op,
    input  smet_pkg::t_link i_link,
    output smet_pkg::t_link o_link,
    output logic           o_hit
);

    logic                       r_valid;
    logic                       r_hit;
    logic [smet_pkg::IDX_W-1:0] r_row;
    logic [smet_pkg::IDX_W-1:0] r_col;
    logic [smet_pkg::VAL_W-1:0] r_value;
    logic                       w_first_free;

    assign w_first_free = !r_valid && !i_link.free_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (i_key.cmp) begin
                r_hit <= r_valid && (r_row == i_key.row) && (r_col == i_key.col);
            end
            if (i_op.clr && r_hit) begin
                r_valid <= 1'b0;
            end else if (i_op.ins && w_first_free) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.ins && w_first_free) begin
            r_row   <= i_op.row;
            r_col   <= i_op.col;
            r_value <= i_op.value;
        end else if (i_op.upd && r_hit) begin
            r_value <= i_op.value;
        end
    end

    always_comb begin
        o_link.free_seen = i_link.free_seen || !r_valid;
        o_link.hit_seen  = i_link.hit_seen || r_hit;
        o_link.rd        = i_link.rd | (r_hit ? r_value : '0);
    end

    assign o_hit = r_hit;

endmodule

// ----- rtl/sparse_matrix_entry_table_top.sv -----
// ---------------------------------------------------------------------------
// sparse_matrix_entry_table_top
// coordinate list store of nonzero matrix entries in a row of cells
//
//   channel   direction   handshake             payload
//   input     in          i_valid / o_stall     i_cmd i_row i_col i_value
//   result    out         o_valid / i_stall     o_read_value o_status
//   config    in          i_cfg_we              i_cfg_index i_cfg_data
//
// each transaction is a compare cycle in every cell at accept,
// then a decide-and-write cycle over the cell chain
// the next transaction can be accepted in the cycle after the previous write
// reset clears all cell valid bits at once, no clearing pass
// a stalled result holds the block in the write cycle until it is taken
// ---------------------------------------------------------------------------
module sparse_matrix_entry_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [15:0]        i_row,
    input  logic [15:0]        i_col,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_read_value,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    smet_pkg::t_state            r_state, n_state;
    smet_pkg::t_cmd              r_cmd;
    logic [smet_pkg::IDX_W-1:0]  r_row, r_col;
    logic [smet_pkg::VAL_W-1:0]  r_value;
    logic [smet_pkg::IDX_W-1:0]  r_num_rows, r_num_cols;
    logic                        r_out_valid;
    logic [smet_pkg::VAL_W-1:0]  r_rd;
    smet_pkg::t_status           r_sts;

    logic                        w_accept;
    logic                        w_fire;
    logic                        w_in_bounds;
    logic [smet_pkg::VAL_W-1:0]  n_rd;
    smet_pkg::t_status           n_sts;
    smet_pkg::t_key              w_key;
    smet_pkg::t_op               w_op;
    smet_pkg::t_link             w_link [smet_pkg::CAPACITY+1];
    logic [smet_pkg::CAPACITY-1:0] w_hits;

    assign o_stall  = (r_state != smet_pkg::S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_fire   = (r_state == smet_pkg::S_EXEC) && (!r_out_valid || !i_stall);

    assign w_key.cmp = w_accept;
    assign w_key.row = i_row;
    assign w_key.col = i_col;

    assign w_link[0] = '0;

    genvar g;
    generate
        for (g = 0; g < smet_pkg::CAPACITY; g++) begin : g_cell
            smet_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_key   (w_key),
                .i_op    (w_op),
                .i_link  (w_link[g]),
                .o_link  (w_link[g+1]),
                .o_hit   (w_hits[g])
            );
        end
    endgenerate

    assign w_in_bounds = (r_row < r_num_rows) && (r_col < r_num_cols);

    always_comb begin
        w_op.upd   = 1'b0;
        w_op.clr   = 1'b0;
        w_op.ins   = 1'b0;
        w_op.row   = r_row;
        w_op.col   = r_col;
        w_op.value = r_value;
        n_rd       = '0;
        n_sts      = smet_pkg::STS_OK;
        unique case (r_cmd)
            smet_pkg::CMD_SET: begin
                if (!w_in_bounds) begin
                    n_sts = smet_pkg::STS_OOB;
                end else if (r_value == '0) begin
                    w_op.clr = w_fire;
                end else if (w_link[smet_pkg::CAPACITY].hit_seen) begin
                    w_op.upd = w_fire;
                end else if (!w_link[smet_pkg::CAPACITY].free_seen) begin
                    n_sts = smet_pkg::STS_FULL;
                end else begin
                    w_op.ins = w_fire;
                end
            end
            smet_pkg::CMD_GET: begin
                n_rd = w_link[smet_pkg::CAPACITY].rd;
            end
            smet_pkg::CMD_DEL: begin
                w_op.clr = w_fire;
            end
            smet_pkg::CMD_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smet_pkg::S_IDLE: if (w_accept) n_state = smet_pkg::S_EXEC;
            smet_pkg::S_EXEC: if (w_fire) n_state = smet_pkg::S_IDLE;
            default: n_state = smet_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smet_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_num_rows  <= '0;
            r_num_cols  <= '0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    smet_pkg::REG_NUM_ROWS: r_num_rows <= i_cfg_data;
                    smet_pkg::REG_NUM_COLS: r_num_cols <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= smet_pkg::t_cmd'(i_cmd);
            r_row   <= i_row;
            r_col   <= i_col;
            r_value <= i_value;
        end
        if (w_fire) begin
            r_rd  <= n_rd;
            r_sts <= n_sts;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_value = r_rd;
    assign o_status     = r_sts;

    // at most one cell ever matches a key
    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hits))
        else $error("more than one cell matches");

    // an accepted transaction moves to the write cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == smet_pkg::S_EXEC))
        else $error("accept did not enter write cycle");

    // a finished write cycle always presents a result
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_valid)
        else $error("result missing after write cycle");

    // only a get returns a nonzero read value, never alongside an error
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != smet_pkg::STS_OK)) |-> (o_read_value == '0))
        else $error("error status with nonzero read value");

endmodule

// ----- tb/smet_reply_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smet_reply_checker
// watches the input, result and config ports of the entry table, keeps its
// own copy of the cell table and dimensions, predicts the reply to every
// accepted transaction and compares each accepted result against the oldest
// prediction
// ---------------------------------------------------------------------------
module smet_reply_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic [15:0]        i_row,
    input  logic [15:0]        i_col,
    input  logic signed [31:0] i_value,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_read_value,
    input  logic [1:0]         i_status,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_replies_owed
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic signed [31:0] rd;
        smet_pkg::t_status  st;
    } t_reply;

    logic               cell_used [smet_pkg::CAPACITY];
    logic [15:0]        cell_row  [smet_pkg::CAPACITY];
    logic [15:0]        cell_col  [smet_pkg::CAPACITY];
    logic signed [31:0] cell_val  [smet_pkg::CAPACITY];
    logic [15:0]        rows_limit;
    logic [15:0]        cols_limit;
    t_reply             predicted_replies [$];
    int                 reply_no;

    function automatic t_reply apply_entry_op(input smet_pkg::t_cmd op,
                                              input logic [15:0] r,
                                              input logic [15:0] c,
                                              input logic signed [31:0] v);
        t_reply rep;
        int     hit;
        int     slot;
        int     k;
        rep.rd = '0;
        rep.st = smet_pkg::STS_OK;
        hit    = -1;
        slot   = -1;
        for (k = 0; k < smet_pkg::CAPACITY; k++) begin
            if (cell_used[k] && cell_row[k] == r && cell_col[k] == c) begin
                hit = k;
            end
        end
        case (op)
            smet_pkg::CMD_SET: begin
                if (r >= rows_limit || c >= cols_limit) begin
                    rep.st = smet_pkg::STS_OOB;
                end else if (v == 0) begin
                    if (hit >= 0) cell_used[hit] = 1'b0;
                end else if (hit >= 0) begin
                    cell_val[hit] = v;
                end else begin
                    // lowest free cell wins
                    for (k = smet_pkg::CAPACITY - 1; k >= 0; k--) begin
                        if (!cell_used[k]) slot = k;
                    end
                    if (slot < 0) begin
                        rep.st = smet_pkg::STS_FULL;
                    end else begin
                        cell_used[slot] = 1'b1;
                        cell_row[slot]  = r;
                        cell_col[slot]  = c;
                        cell_val[slot]  = v;
                    end
                end
            end
            smet_pkg::CMD_GET: begin
                if (hit >= 0) rep.rd = cell_val[hit];
            end
            smet_pkg::CMD_DEL: begin
                if (hit >= 0) cell_used[hit] = 1'b0;
            end
            default: begin
            end
        endcase
        return rep;
    endfunction

    // ports settle between edges, so the negedge sees what the next posedge takes
    always @(negedge i_clk) begin
        t_reply exp_rep;
        int     k;
        if (!i_rst_n) begin
            for (k = 0; k < smet_pkg::CAPACITY; k++) cell_used[k] = 1'b0;
            rows_limit = '0;
            cols_limit = '0;
            predicted_replies.delete();
            o_replies_owed = 0;
            o_fail_count   = 0;
            reply_no       = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                reply_no++;
                if (predicted_replies.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS) begin
                        $display("result %0d arrived with no transaction outstanding",
                                 reply_no);
                    end
                end else begin
                    exp_rep = predicted_replies.pop_front();
                    if (i_read_value !== exp_rep.rd || i_status !== exp_rep.st) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTS) begin
                            $display({"result %0d: read_value exp %0d got %0d, ",
                                      "status exp %0d got %0d"},
                                     reply_no, exp_rep.rd, i_read_value,
                                     exp_rep.st, i_status);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == smet_pkg::REG_NUM_ROWS) begin
                    rows_limit = i_cfg_data;
                end else begin
                    cols_limit = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predicted_replies.push_back(
                    apply_entry_op(smet_pkg::t_cmd'(i_cmd), i_row, i_col, i_value));
            end
            o_replies_owed = predicted_replies.size();
        end
    end

endmodule

// ----- tb/sparse_matrix_entry_table_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sparse_matrix_entry_table_top_tb
// drives set, get and delete transactions into the entry table under a
// series of matrix dimensions, with random idling on both channels, a long
// result hold-off, a mid-run drain and a table fill past capacity; the
// checker predicts and compares every result
// ---------------------------------------------------------------------------
module sparse_matrix_entry_table_top_tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int N_PHASES       = 9;
    localparam int OPS_PER_PHASE  = 175;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         cmd;
    logic [15:0]        row;
    logic [15:0]        col;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic               cfg_we;
    logic               cfg_index;
    logic [15:0]        cfg_data;

    int                 fail_count;
    int                 replies_owed;
    int                 stall_cycles = 0;
    logic [15:0]        dim_rows;
    logic [15:0]        dim_cols;
    bit                 tx_idle_en = 1'b0;
    bit                 rx_idle_en = 1'b0;
    bit                 rx_hold    = 1'b0;

    logic [15:0] phase_rows [N_PHASES] = '{16'd10, 16'd16, 16'd1, 16'hFFFF, 16'd3,
                                           16'hFFFF, 16'd0, 16'd9, 16'd12};
    logic [15:0] phase_cols [N_PHASES] = '{16'd10, 16'd16, 16'd1, 16'hFFFF, 16'hFFFF,
                                           16'd2, 16'd7, 16'd9, 16'd12};

    sparse_matrix_entry_table_top u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_cmd        (cmd),
        .i_row        (row),
        .i_col        (col),
        .i_value      (value),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_read_value (read_value),
        .o_status     (status),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    smet_reply_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_cmd          (cmd),
        .i_row          (row),
        .i_col          (col),
        .i_value        (value),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_read_value   (read_value),
        .i_status       (status),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_replies_owed (replies_owed)
    );

    always #5 clk = ~clk;

    // watchdog on cycles with no transaction on any port
    always @(negedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side stall pattern
    initial begin
        forever begin
            if (rx_hold) begin
                out_stall <= 1'b1;
                rx_hold = 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    task automatic send_op(input smet_pkg::t_cmd op_cmd, input logic [15:0] op_row,
                           input logic [15:0] op_col, input logic [31:0] op_value);
        bit took;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op_cmd;
        row      <= op_row;
        col      <= op_col;
        value    <= op_value;
        do begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end while (!took);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (replies_owed != 0);
    endtask

    task automatic set_dims(input logic [15:0] r, input logic [15:0] c);
        cfg_we    <= 1'b1;
        cfg_index <= smet_pkg::REG_NUM_ROWS;
        cfg_data  <= r;
        @(posedge clk);
        cfg_index <= smet_pkg::REG_NUM_COLS;
        cfg_data  <= c;
        @(posedge clk);
        cfg_we    <= 1'b0;
        dim_rows = r;
        dim_cols = c;
    endtask

    // mostly a small in-bounds window so keys repeat, plus the bounds edge and noise
    function automatic logic [15:0] pick_index(input logic [15:0] dim);
        int sel;
        int span;
        sel  = $urandom_range(0, 99);
        span = (dim == 0) ? 1 : ((dim < 12) ? int'(dim) : 12);
        if (sel < 80) return 16'($urandom_range(0, span - 1));
        else if (sel < 88) return (dim == 0) ? 16'd0 : dim - 16'd1;
        else if (sel < 93) return dim;
        else return 16'($urandom);
    endfunction

    task automatic send_random_op();
        smet_pkg::t_cmd op;
        int             sel;
        logic [31:0]    v;
        logic [15:0]    r;
        logic [15:0]    c;
        sel = $urandom_range(0, 99);
        if (sel < 55) op = smet_pkg::CMD_SET;
        else if (sel < 80) op = smet_pkg::CMD_GET;
        else if (sel < 92) op = smet_pkg::CMD_DEL;
        else op = smet_pkg::CMD_NOP;
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
            v = '0;
        end else if (sel < 20) begin
            case ($urandom_range(0, 3))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'hFFFF_FFFF;
                default: v = 32'h0000_0001;
            endcase
        end else begin
            v = $urandom;
        end
        r = pick_index(dim_rows);
        c = pick_index(dim_cols);
        send_op(op, r, c, v);
    endtask

    initial begin
        int          p;
        int          n;
        int          k;
        logic [31:0] v;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cmd       <= smet_pkg::CMD_NOP;
        row       <= '0;
        col       <= '0;
        value     <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= smet_pkg::REG_NUM_ROWS;
        cfg_data  <= '0;
        dim_rows = '0;
        dim_cols = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        rx_idle_en = 1'b1;

        // dimensions still zero: every set is refused
        send_op(smet_pkg::CMD_SET, 16'd0, 16'd0, 32'd5);
        send_op(smet_pkg::CMD_GET, 16'd0, 16'd0, 32'd0);
        wait_drained();
        set_dims(16'd8, 16'd8);
        send_op(smet_pkg::CMD_SET, 16'd0, 16'd0, 32'h7FFF_FFFF);
        send_op(smet_pkg::CMD_GET, 16'd0, 16'd0, 32'd0);
        send_op(smet_pkg::CMD_SET, 16'd0, 16'd0, 32'h8000_0000);
        send_op(smet_pkg::CMD_GET, 16'd0, 16'd0, 32'd0);
        send_op(smet_pkg::CMD_SET, 16'd7, 16'd7, 32'hFFFF_FFFF);
        send_op(smet_pkg::CMD_SET, 16'd8, 16'd0, 32'd9);
        send_op(smet_pkg::CMD_SET, 16'd0, 16'd8, 32'd9);
        send_op(smet_pkg::CMD_SET, 16'd8, 16'd8, 32'd0);
        send_op(smet_pkg::CMD_GET, 16'd7, 16'd7, 32'd0);
        send_op(smet_pkg::CMD_SET, 16'd7, 16'd7, 32'd0);
        send_op(smet_pkg::CMD_GET, 16'd7, 16'd7, 32'd0);
        send_op(smet_pkg::CMD_DEL, 16'd3, 16'd3, 32'd0);
        send_op(smet_pkg::CMD_DEL, 16'd0, 16'd0, 32'd0);
        send_op(smet_pkg::CMD_GET, 16'd0, 16'd0, 32'd0);
        send_op(smet_pkg::CMD_NOP, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_op(smet_pkg::CMD_GET, 16'hFFFF, 16'hFFFF, 32'd0);
        send_op(smet_pkg::CMD_DEL, 16'hFFFF, 16'hFFFF, 32'd0);

        for (p = 0; p < N_PHASES; p++) begin
            wait_drained();
            if (p == N_PHASES - 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end else begin
                tx_idle_en = (p != 4);
                rx_idle_en = 1'b1;
            end
            set_dims(phase_rows[p], phase_cols[p]);
            if (phase_rows[p] == 16'd9) begin
                // walk every key of a 9x9 matrix so the table overflows
                for (k = 0; k < 81; k++) begin
                    v = $urandom;
                    if (v == 0) v = 32'd1;
                    send_op(smet_pkg::CMD_SET, 16'(k / 9), 16'(k % 9), v);
                end
            end
            for (n = 0; n < OPS_PER_PHASE; n++) begin
                if (p == 1 && n == 20) rx_hold = 1'b1;
                if (p == 3 && n == OPS_PER_PHASE / 2) wait_drained();
                send_random_op();
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && replies_owed == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/smet_pkg.sv
rtl/smet_cell.sv
rtl/sparse_matrix_entry_table_top.sv
tb/smet_reply_checker.sv
tb/sparse_matrix_entry_table_top_tb.sv
